// ----- rtl/ssdg_pkg.sv -----
`default_nettype none

package ssdg_pkg;

    // fixed field widths at the ports
    localparam int TARGET_BITS      = 32;
    localparam int INTERVAL_IN_BITS = 20;
    localparam int PULSE_BITS       = 10;
    localparam int POS_OUT_BITS     = 32;

    // reset values
    localparam int RESET_INTERVAL    = 800;
    localparam int RESET_PULSE_WIDTH = 10;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_MOVE_TO   = 3'd1,
        ACT_RUN       = 3'd2,
        ACT_STOP      = 3'd3,
        ACT_RESET_POS = 3'd4
    } ssdg_action_t;

    typedef struct packed {
        logic [2:0]                    action;
        logic signed [TARGET_BITS-1:0] target;
        logic [INTERVAL_IN_BITS-1:0]   interval_us;
        logic                          direction;
    } ssdg_cmd_t;

    typedef struct packed {
        logic                           step_out;
        logic                           dir_out;
        logic                           is_running;
        logic                           is_continuous;
        logic signed [POS_OUT_BITS-1:0] position;
    } ssdg_res_t;

endpackage

`default_nettype wire

// ----- rtl/ssdg_if.sv -----
`default_nettype none

// command request channel
interface ssdg_cmd_if
    import ssdg_pkg::*;
;
    logic                               valid;
    logic                               ready;
    logic [2:0]                         action;
    logic signed [TARGET_BITS-1:0]      target;
    logic [INTERVAL_IN_BITS-1:0]        interval_us;
    logic                               direction;

    modport source (output valid, output action, output target, output interval_us,
                    output direction, input ready);
    modport sink   (input valid, input action, input target, input interval_us,
                    input direction, output ready);
endinterface

// result request channel
interface ssdg_res_if
    import ssdg_pkg::*;
;
    logic                               valid;
    logic                               ready;
    logic                               step_out;
    logic                               dir_out;
    logic                               is_running;
    logic                               is_continuous;
    logic signed [POS_OUT_BITS-1:0]     position;

    modport source (output valid, output step_out, output dir_out, output is_running,
                    output is_continuous, output position, input ready);
    modport sink   (input valid, input step_out, input dir_out, input is_running,
                    input is_continuous, input position, output ready);
endinterface

// pulse width register write channel
interface ssdg_cfg_if
    import ssdg_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [PULSE_BITS-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ssdg_core.sv -----
`default_nettype none

module ssdg_core
    import ssdg_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int INTERVAL_BITS = 20
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire ssdg_cmd_t             cmd,
    input  wire logic [PULSE_BITS-1:0] pulse_width,
    output ssdg_res_t                  res_next
);

    logic [POSITION_BITS-1:0] cur_pos_reg, cur_pos_next;
    logic [POSITION_BITS-1:0] tgt_pos_reg, tgt_pos_next;
    logic [INTERVAL_BITS-1:0] interval_reg, interval_next;
    logic [INTERVAL_BITS-1:0] since_reg, since_next;
    logic [PULSE_BITS-1:0]    pulse_el_reg, pulse_el_next;
    logic                     pulse_act_reg, pulse_act_next;
    logic                     running_reg, running_next;
    logic                     cont_reg, cont_next;
    logic                     dir_reg, dir_next;

    logic [POSITION_BITS-1:0] cmd_tgt;
    logic [INTERVAL_BITS-1:0] cmd_ival;
    logic [INTERVAL_BITS-1:0] since_inc;
    logic [PULSE_BITS-1:0]    pulse_inc;
    logic [POSITION_BITS-1:0] pos_up, pos_dn;
    logic                     pulse_hold;
    logic                     step_fire;
    logic                     up_reached, dn_reached;
    logic                     cur_lt_tgt, tgt_lt_cur;

    // command fields brought to internal widths
    assign cmd_tgt  = POSITION_BITS'(cmd.target);
    assign cmd_ival = INTERVAL_BITS'(cmd.interval_us);

    // saturating elapsed-time counters
    assign since_inc = (since_reg == '1) ? since_reg : since_reg + 1'b1;
    assign pulse_inc = (pulse_el_reg == '1) ? pulse_el_reg : pulse_el_reg + 1'b1;

    // pulse still inside its width blocks stepping on this tick
    assign pulse_hold = pulse_act_reg && (pulse_inc < pulse_width);
    assign step_fire  = accept && (ssdg_action_t'(cmd.action) == ACT_TICK) && !pulse_hold
                        && running_reg && (since_inc >= interval_reg);

    assign pos_up     = cur_pos_reg + 1'b1;
    assign pos_dn     = cur_pos_reg - 1'b1;
    assign up_reached = !($signed(pos_up) < $signed(tgt_pos_reg));
    assign dn_reached = !($signed(tgt_pos_reg) < $signed(pos_dn));
    assign cur_lt_tgt = $signed(cur_pos_reg) < $signed(cmd_tgt);
    assign tgt_lt_cur = $signed(cmd_tgt) < $signed(cur_pos_reg);

    always_comb
    begin
        cur_pos_next   = cur_pos_reg;
        tgt_pos_next   = tgt_pos_reg;
        interval_next  = interval_reg;
        since_next     = since_reg;
        pulse_el_next  = pulse_el_reg;
        pulse_act_next = pulse_act_reg;
        running_next   = running_reg;
        cont_next      = cont_reg;
        dir_next       = dir_reg;
        if (accept)
        begin
            case (ssdg_action_t'(cmd.action))
                ACT_TICK:
                begin
                    since_next     = since_inc;
                    pulse_el_next  = pulse_inc;
                    pulse_act_next = pulse_hold;
                    if (step_fire)
                    begin
                        since_next     = '0;
                        pulse_act_next = 1'b1;
                        pulse_el_next  = '0;
                        cur_pos_next   = dir_reg ? pos_up : pos_dn;
                        if (!cont_reg && (dir_reg ? up_reached : dn_reached))
                        begin
                            running_next = 1'b0;
                        end
                    end
                end
                ACT_MOVE_TO:
                begin
                    tgt_pos_next  = cmd_tgt;
                    interval_next = cmd_ival;
                    cont_next     = 1'b0;
                    if (cur_lt_tgt || tgt_lt_cur)
                    begin
                        dir_next     = cur_lt_tgt;
                        since_next   = '0;
                        running_next = 1'b1;
                    end
                    else
                    begin
                        running_next = 1'b0;
                    end
                end
                ACT_RUN:
                begin
                    if (!running_reg || (dir_reg != cmd.direction) || (interval_reg != cmd_ival))
                    begin
                        dir_next      = cmd.direction;
                        interval_next = cmd_ival;
                        cont_next     = 1'b1;
                        since_next    = '0;
                        running_next  = 1'b1;
                    end
                end
                ACT_STOP:
                begin
                    running_next = 1'b0;
                end
                ACT_RESET_POS:
                begin
                    cur_pos_next = '0;
                end
                default:
                begin
                    // unused codes leave the state alone
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg   <= '0;
            tgt_pos_reg   <= '0;
            interval_reg  <= INTERVAL_BITS'(RESET_INTERVAL);
            since_reg     <= '0;
            pulse_el_reg  <= '0;
            pulse_act_reg <= 1'b0;
            running_reg   <= 1'b0;
            cont_reg      <= 1'b0;
            dir_reg       <= 1'b0;
        end
        else
        begin
            cur_pos_reg   <= cur_pos_next;
            tgt_pos_reg   <= tgt_pos_next;
            interval_reg  <= interval_next;
            since_reg     <= since_next;
            pulse_el_reg  <= pulse_el_next;
            pulse_act_reg <= pulse_act_next;
            running_reg   <= running_next;
            cont_reg      <= cont_next;
            dir_reg       <= dir_next;
        end
    end

    // result reflects the state after this item
    always_comb
    begin
        res_next.step_out      = pulse_act_next;
        res_next.dir_out       = dir_next;
        res_next.is_running    = running_next;
        res_next.is_continuous = cont_next;
        res_next.position      = POS_OUT_BITS'(cur_pos_next);
    end

    // a step always starts a fresh pulse
    a_step_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> (pulse_act_reg && (pulse_el_reg == '0)))
        else $error("step without fresh pulse");

    // position only moves on an accepted request
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(cur_pos_reg))
        else $error("position moved without request");

    // stop always clears running
    a_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (ssdg_action_t'(cmd.action) == ACT_STOP)) |=> !running_reg)
        else $error("stop left motor running");

    // a tick during a held pulse never steps
    a_hold_no_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (ssdg_action_t'(cmd.action) == ACT_TICK) && pulse_hold)
        |=> $stable(cur_pos_reg))
        else $error("step during active pulse");

endmodule

`default_nettype wire

// ----- rtl/ssdg_res_buf.sv -----
`default_nettype none

module ssdg_res_buf
    import ssdg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire ssdg_res_t push_data,
    output logic           space,
    output logic           head_valid,
    output ssdg_res_t      head_data,
    input  wire logic      pop
);

    logic [1:0] count_reg, count_next;
    ssdg_res_t  ent0_reg, ent0_next;
    ssdg_res_t  ent1_reg, ent1_next;
    logic       do_pop;

    assign do_pop     = pop && (count_reg != 2'd0);
    assign space      = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = ent0_reg;

    always_comb
    begin
        count_next = count_reg;
        ent0_next  = ent0_reg;
        ent1_next  = ent1_reg;
        if (do_pop)
        begin
            ent0_next = ent1_reg;
        end
        if (push)
        begin
            if ((count_reg == 2'd0) || ((count_reg == 2'd1) && do_pop))
            begin
                ent0_next = push_data;
            end
            else
            begin
                ent1_next = push_data;
            end
        end
        count_next = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entries carry payload only
    always_ff @(posedge clk)
    begin
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> !push)
        else $error("result buffer overflow");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    a_pop_empties: assert property (@(posedge clk) disable iff (!rst_n)
        ((count_reg == 2'd1) && do_pop && !push) |=> !head_valid)
        else $error("result buffer not empty after last pop");

endmodule

`default_nettype wire

// ----- rtl/stepper_step_dir_generator.sv -----
`default_nettype none

// channel | dir | fields                                     | accepted when
// --------+-----+--------------------------------------------+--------------------------
// cmd     | in  | action, target, interval_us, direction     | cmd.valid && cmd.ready
// res     | out | step_out, dir_out, is_running,             | res.valid && res.ready
//         |     | is_continuous, position                    |
// cfg     | in  | data (pulse_width_us)                      | cfg.valid && cfg.ready
//
// one request per clock while cmd.ready is high: each tick or command updates the state
// in the cycle it is taken; its result enters a two-entry result buffer, visible the next cycle
// cmd.ready drops only while both buffer entries hold results not yet taken
// cfg.ready is always high; write the pulse width only while no request is in flight
// rst_n clears position, target and flags, loads a step interval of 800 ticks and
// a pulse width of 10 ticks; no clearing pass, cmd.ready is up right after reset

module stepper_step_dir_generator
    import ssdg_pkg::*;
#(
    parameter int POSITION_BITS = 32,
    parameter int INTERVAL_BITS = 20
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ssdg_cmd_if.sink  cmd,
    ssdg_res_if.source res,
    ssdg_cfg_if.sink  cfg
);

    // pulse width register
    logic [PULSE_BITS-1:0] pulse_width_reg;

    ssdg_cmd_t  cmd_data;
    ssdg_res_t  res_new;
    ssdg_res_t  res_head;
    logic       buf_space;
    logic       cmd_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_width_reg <= PULSE_BITS'(RESET_PULSE_WIDTH);
        end
        else if (cfg.valid)
        begin
            pulse_width_reg <= cfg.data;
        end
    end

    // request taken whenever the result buffer has room
    assign cmd.ready = buf_space;
    assign cmd_take  = cmd.valid && buf_space;

    always_comb
    begin
        cmd_data.action      = cmd.action;
        cmd_data.target      = cmd.target;
        cmd_data.interval_us = cmd.interval_us;
        cmd_data.direction   = cmd.direction;
    end

    // step/direction state and per-request update
    ssdg_core #(
        .POSITION_BITS (POSITION_BITS),
        .INTERVAL_BITS (INTERVAL_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (cmd_take),
        .cmd         (cmd_data),
        .pulse_width (pulse_width_reg),
        .res_next    (res_new)
    );

    // result buffer decouples result backpressure from command intake
    ssdg_res_buf u_res_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (cmd_take),
        .push_data  (res_new),
        .space      (buf_space),
        .head_valid (res.valid),
        .head_data  (res_head),
        .pop        (res.ready)
    );

    assign res.step_out      = res_head.step_out;
    assign res.dir_out       = res_head.dir_out;
    assign res.is_running    = res_head.is_running;
    assign res.is_continuous = res_head.is_continuous;
    assign res.position      = res_head.position;

endmodule

`default_nettype wire
